// ===== src/sdf_pkg.sv =====
`timescale 1ns / 1ps
package sdf_pkg;

  localparam int WORD_W      = 32;
  localparam int NORM_W      = 31;
  localparam int POS_W       = 16;
  localparam int DEN_W       = 2 * NORM_W;
  localparam int REM_W       = DEN_W + 1;
  // Quotient bits kept by the divider; anything at or above 2^QUO_W saturates.
  localparam int QUO_W       = 33;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] MODE_DOT    = 2'd0;
  localparam logic [1:0] MODE_EUCLID = 2'd1;
  localparam logic [1:0] MODE_NORMED = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ABSOLUTE_ENABLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ABSOLUTE_FLOOR  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_ENABLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_LIMIT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_ENABLE   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS          = 3'd6;

  localparam logic signed [WORD_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] DIST_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] dot_sum;
    logic [NORM_W-1:0]        query_norm;
    logic [NORM_W-1:0]        item_norm;
    logic signed [WORD_W-1:0] query_power;
    logic signed [WORD_W-1:0] item_power;
    logic [POS_W-1:0]         query_position;
    logic [POS_W-1:0]         item_position;
    logic [POS_W-1:0]         track_index;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] distance;
    logic                     accepted;
    logic                     divide_fault;
    logic [POS_W-1:0]         query_position_out;
    logic [POS_W-1:0]         item_position_out;
    logic [POS_W-1:0]         track_index_out;
  } result_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic                     abs_en;
    logic signed [WORD_W-1:0] abs_floor;
    logic                     rel_en;
    logic [NORM_W-1:0]        rel_limit;
    logic                     rad_en;
    logic signed [WORD_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] query_position;
    logic [POS_W-1:0] item_position;
    logic [POS_W-1:0] track_index;
  } tag_t;

  typedef struct packed {
    logic [DEN_W-1:0]         qq;
    logic [DEN_W-1:0]         ss;
    logic [DEN_W-1:0]         den;
    logic signed [WORD_W-1:0] dot;
    logic [WORD_W-1:0]        mag;
    logic                     abs_ok;
    logic signed [WORD_W:0]   pdiff;
    tag_t                     tag;
  } front_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] dot;
    logic [REM_W-1:0]         sq;
    logic                     ovf;
    logic                     fault;
    logic                     power_ok;
    tag_t                     tag;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] tail;
    logic [QUO_W-1:0] quo;
    side_t            side;
  } step_t;

endpackage

// ===== src/sdf_front.sv =====
`timescale 1ns / 1ps
module sdf_front import sdf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   prev_valid,
  input  item_t  prev,
  input  cfg_t   cfg,
  output logic   valid,
  output front_t stage
);

  front_t            stage_next;
  logic [WORD_W-1:0] dot_u;

  // Three norm products in parallel, one multiplier each.
  always_comb begin
    dot_u                = prev.dot_sum;
    stage_next.qq        = prev.query_norm * prev.query_norm;
    stage_next.ss        = prev.item_norm * prev.item_norm;
    stage_next.den       = prev.query_norm * prev.item_norm;
    stage_next.dot       = prev.dot_sum;
    stage_next.mag       = dot_u[WORD_W-1] ? (~dot_u + 32'd1) : dot_u;
    stage_next.abs_ok    = !cfg.abs_en ||
                           !((prev.query_power < cfg.abs_floor) ||
                             (prev.item_power < cfg.abs_floor));
    stage_next.pdiff     = {prev.query_power[WORD_W-1], prev.query_power} -
                           {prev.item_power[WORD_W-1], prev.item_power};
    stage_next.tag.query_position = prev.query_position;
    stage_next.tag.item_position  = prev.item_position;
    stage_next.tag.track_index    = prev.track_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== src/sdf_prep.sv =====
`timescale 1ns / 1ps
module sdf_prep import sdf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   prev_valid,
  input  front_t prev,
  input  cfg_t   cfg,
  output logic   valid,
  output step_t  stage
);

  localparam int SHIFT = 2 * FRAC_BITS + 1;
  localparam int NUM_W = WORD_W + SHIFT;

  step_t            stage_next;
  logic [NUM_W-1:0] num;
  logic [WORD_W:0]  pabs;
  logic [REM_W-1:0] sq_sum;
  logic             rel_ok;

  // The dividend is |dot| scaled by 2^(2F+1). Its bits above QUO_W seed the
  // remainder; if that seed already reaches the divisor the quotient
  // overflows the kept width and the result saturates.
  always_comb begin
    num    = {prev.mag, {SHIFT{1'b0}}};
    pabs   = prev.pdiff[WORD_W] ? (~prev.pdiff + 33'd1) : prev.pdiff;
    rel_ok = !cfg.rel_en || (pabs <= {2'b00, cfg.rel_limit});
    sq_sum = {1'b0, prev.qq} + {1'b0, prev.ss};

    stage_next.rem           = REM_W'(num[NUM_W-1:QUO_W]);
    stage_next.den           = prev.den;
    stage_next.tail          = num[QUO_W-1:0];
    stage_next.quo           = '0;
    stage_next.side.dot      = prev.dot;
    stage_next.side.sq       = sq_sum >> FRAC_BITS;
    stage_next.side.ovf      = REM_W'(num[NUM_W-1:QUO_W]) >= {1'b0, prev.den};
    stage_next.side.fault    = (prev.den == '0);
    stage_next.side.power_ok = prev.abs_ok && rel_ok;
    stage_next.side.tag      = prev.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== src/sdf_div_step.sv =====
`timescale 1ns / 1ps
module sdf_div_step import sdf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  prev_valid,
  input  step_t prev,
  output logic  valid,
  output step_t stage
);

  step_t            stage_next;
  logic [REM_W-1:0] shifted;
  logic [REM_W:0]   diff;

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    shifted         = {prev.rem[REM_W-2:0], prev.tail[QUO_W-1]};
    diff            = {1'b0, shifted} - {2'b00, prev.den};
    stage_next      = prev;
    stage_next.rem  = diff[REM_W] ? shifted : diff[REM_W-1:0];
    stage_next.tail = {prev.tail[QUO_W-2:0], 1'b0};
    stage_next.quo  = {prev.quo[QUO_W-2:0], ~diff[REM_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== src/sdf_back.sv =====
`timescale 1ns / 1ps
module sdf_back import sdf_pkg::*; #(
  parameter int FRAC_BITS          = 16,
  parameter int DISTANCE_TOLERANCE = 1
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    prev_valid,
  input  step_t   prev,
  input  cfg_t    cfg,
  output logic    valid,
  output result_t result
);

  localparam int         NSUM_W    = QUO_W + 3;
  localparam int         EUC_W     = REM_W + 2;
  localparam logic [NSUM_W-1:0] NORM_BASE = NSUM_W'(1) << (FRAC_BITS + 1);

  logic [NSUM_W-1:0]        nsum;
  logic [EUC_W-1:0]         euc;
  logic signed [WORD_W-1:0] normed;
  logic signed [WORD_W-1:0] euc_sat;
  logic signed [WORD_W-1:0] dist_next;
  logic                     dot_neg;
  logic                     dot_pos;

  logic                     sel_valid;
  logic signed [WORD_W-1:0] distance;
  logic                     fault;
  logic                     power_ok;
  tag_t                     tag;

  logic signed [WORD_W+1:0] dist_ext;
  logic signed [WORD_W+1:0] limit;
  logic                     rad_ok;

  // First stage: form both distances, saturate, pick by mode.
  always_comb begin
    dot_neg = prev.side.dot[WORD_W-1];
    dot_pos = !dot_neg && (prev.side.dot != '0);

    nsum = dot_neg ? (NORM_BASE + {3'b000, prev.quo}) : (NORM_BASE - {3'b000, prev.quo});
    if (prev.side.fault) begin
      normed = dot_pos ? DIST_MIN : DIST_MAX;
    end else if (prev.side.ovf) begin
      normed = dot_neg ? DIST_MAX : DIST_MIN;
    end else if ((nsum[NSUM_W-1:WORD_W-1] == '0) || (nsum[NSUM_W-1:WORD_W-1] == '1)) begin
      normed = nsum[WORD_W-1:0];
    end else begin
      normed = nsum[NSUM_W-1] ? DIST_MIN : DIST_MAX;
    end

    euc = {2'b00, prev.side.sq} - {{(EUC_W-WORD_W-1){prev.side.dot[WORD_W-1]}},
                                   prev.side.dot, 1'b0};
    if ((euc[EUC_W-1:WORD_W-1] == '0) || (euc[EUC_W-1:WORD_W-1] == '1)) begin
      euc_sat = euc[WORD_W-1:0];
    end else begin
      euc_sat = euc[EUC_W-1] ? DIST_MIN : DIST_MAX;
    end

    case (cfg.mode)
      MODE_DOT:    dist_next = prev.side.dot;
      MODE_EUCLID: dist_next = euc_sat;
      MODE_NORMED: dist_next = normed;
      MODE_NONE:   dist_next = '0;
      default:     dist_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (advance) begin
      sel_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      distance <= dist_next;
      fault    <= (cfg.mode == MODE_NORMED) && prev.side.fault;
      power_ok <= prev.side.power_ok;
      tag      <= prev.side.tag;
    end
  end

  // Second stage: radius test against radius plus tolerance, taken wide.
  always_comb begin
    dist_ext = {{2{distance[WORD_W-1]}}, distance};
    limit    = {{2{cfg.radius[WORD_W-1]}}, cfg.radius} + (WORD_W+2)'(DISTANCE_TOLERANCE);
    rad_ok   = !cfg.rad_en || !(dist_ext > limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.distance           <= distance;
      result.accepted           <= power_ok && rad_ok;
      result.divide_fault       <= fault;
      result.query_position_out <= tag.query_position;
      result.item_position_out  <= tag.item_position;
      result.track_index_out    <= tag.track_index;
    end
  end

endmodule

// ===== src/shingle_distance_filter.sv =====
`timescale 1ns / 1ps
// Distance scorer and filter for candidate shingle pairs. Each request carries
// a windowed dot product, two window norms, two mean powers and three position
// tags; each produces exactly one result with a saturated Q16.16 distance
// (dot product, Euclidean, normed Euclidean or zero, as chosen by distance_mode),
// an accept flag from the power floor, power difference and radius tests,
// a divide fault flag for a zero norm product in normed mode, and the tags.
// The block takes one request per clock while no held result is stalled, and
// it is built from one stage of norm multipliers, one stage that seeds the
// division, 33 stages of the restoring divider at one quotient bit each, a
// distance select stage and a radius compare stage that is also the output
// register. A stall on the result side while a result waits freezes the
// whole pipeline and raises item_stall in the same cycle; bubbles move along
// with the data. Configuration writes are always taken (cfg_ready is held
// high) and should only be issued while no request is in flight.
module shingle_distance_filter import sdf_pkg::*; #(
  parameter int FRAC_BITS          = 16,
  parameter int DISTANCE_TOLERANCE = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t   cfg;
  logic   advance;

  logic   front_valid;
  front_t front;

  logic   chain_valid [0:QUO_W];
  step_t  chain       [0:QUO_W];

  // The pipeline moves as one unit; it only holds when a finished result
  // sits at the output and the consumer is stalling it.
  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;
  assign cfg_ready  = 1'b1;

  // Configuration registers. Unused data bits are dropped and writes to
  // indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_EUCLID;
      cfg.abs_en    <= 1'b0;
      cfg.abs_floor <= '0;
      cfg.rel_en    <= 1'b0;
      cfg.rel_limit <= '0;
      cfg.rad_en    <= 1'b0;
      cfg.radius    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DISTANCE_MODE:   cfg.mode      <= cfg_data[1:0];
        REG_ABSOLUTE_ENABLE: cfg.abs_en    <= cfg_data[0];
        REG_ABSOLUTE_FLOOR:  cfg.abs_floor <= cfg_data[WORD_W-1:0];
        REG_RELATIVE_ENABLE: cfg.rel_en    <= cfg_data[0];
        REG_RELATIVE_LIMIT:  cfg.rel_limit <= cfg_data[NORM_W-1:0];
        REG_RADIUS_ENABLE:   cfg.rad_en    <= cfg_data[0];
        REG_RADIUS:          cfg.radius    <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: norm products, |dot| and the power floor test.
  sdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .prev_valid (item_valid),
    .prev       (item),
    .cfg        (cfg),
    .valid      (front_valid),
    .stage      (front)
  );

  // Stage 2: power difference test, squared-norm sum and divider seed.
  sdf_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .prev_valid (front_valid),
    .prev       (front),
    .cfg        (cfg),
    .valid      (chain_valid[0]),
    .stage      (chain[0])
  );

  // Divider: one quotient bit per stage, most significant first.
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    sdf_div_step u_step (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .prev_valid (chain_valid[g]),
      .prev       (chain[g]),
      .valid      (chain_valid[g+1]),
      .stage      (chain[g+1])
    );
  end

  // Distance select, saturation and the radius test; drives the output.
  sdf_back #(
    .FRAC_BITS          (FRAC_BITS),
    .DISTANCE_TOLERANCE (DISTANCE_TOLERANCE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .prev_valid (chain_valid[QUO_W]),
    .prev       (chain[QUO_W]),
    .cfg        (cfg),
    .valid      (result_valid),
    .result     (result)
  );

  // A divide fault can only come out of normed mode.
  a_fault_mode: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.divide_fault) |-> (cfg.mode == MODE_NORMED))
    else $error("divide fault reported outside normed mode");

  // A divide fault always pins the distance to one end of the range.
  a_fault_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.divide_fault) |->
      ((result.distance == DIST_MIN) || (result.distance == DIST_MAX)))
    else $error("divide fault with an unsaturated distance");

  // With every test switched off, every pair must be kept.
  a_no_tests: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !cfg.abs_en && !cfg.rel_en && !cfg.rad_en) |-> result.accepted)
    else $error("pair rejected with all tests disabled");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb import sdf_pkg::*; ();

  localparam int FRAC_BITS          = 16;
  localparam int DISTANCE_TOLERANCE = 1;

  // Pipeline depth allowance at the default settings: multipliers, divider seed,
  // one divider stage per quotient bit, distance select and radius compare.
  localparam int PIPE_LATENCY = QUO_W + 4;

  // The run is declared hung after this many cycles in a row in which no
  // request, result or register write is taken. The slowest legal gap is the
  // pipeline fill plus a long run of receiver stalls, far below this.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int RANDOM_PHASES   = 24;
  localparam int PAIRS_PER_PHASE = 77;
  localparam int REPORT_LIMIT    = 100;

  // The normed quotient is clamped here; the value already saturates any
  // distance, so the clamp only keeps the arithmetic bounded.
  localparam longint QUOTIENT_CAP = longint'(1) << 40;
  // 2.0 in fixed point, the starting point of the normed distance.
  localparam longint NORMED_BASE  = longint'(2) << FRAC_BITS;

  localparam logic signed [WORD_W-1:0] ONE      = 32'sh0001_0000;
  localparam logic [NORM_W-1:0]        NORM_MAX = {NORM_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  // Requests waiting to be offered, and the scores owed by the block for the
  // requests it has already taken, oldest first.
  item_t   pending_pairs[$];
  result_t expected_scores[$];

  // Our own copy of the register file, updated as each write is taken.
  cfg_t regs;

  // Percentages of cycles in which the sender holds back a request and the
  // receiver stalls a result. They change from one phase to the next.
  int send_gap_pct = 0;
  int stall_pct    = 0;

  int mismatches   = 0;
  int quiet_cycles = 0;

  shingle_distance_filter #(
    .FRAC_BITS         (FRAC_BITS),
    .DISTANCE_TOLERANCE(DISTANCE_TOLERANCE)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scores one candidate pair under the given register settings. All of the
  // arithmetic is done in 128 bits so that every intermediate is exact, and
  // saturation happens only on the final distance and the normed quotient.
  function automatic result_t score_pair(input item_t it, input cfg_t c);
    logic signed [127:0] dot;
    logic signed [127:0] distance;
    logic signed [127:0] gap;
    logic signed [127:0] quo;
    logic [127:0]        qn;
    logic [127:0]        sn;
    logic [127:0]        den;
    logic [127:0]        mag;
    logic                fault;
    logic                pass;
    result_t             r;
    dot   = $signed(it.dot_sum);
    qn    = it.query_norm;
    sn    = it.item_norm;
    fault = 1'b0;
    case (c.mode)
      MODE_DOT: begin
        distance = dot;
      end
      MODE_EUCLID: begin
        // The squared norms carry twice the fraction bits; floor back to one.
        distance = $signed((qn * qn + sn * sn) >> FRAC_BITS) - 2 * dot;
      end
      MODE_NORMED: begin
        den = qn * sn;
        if (den == 0) begin
          // A zero norm product has no quotient. The distance goes to the
          // rail opposite the sign the quotient would have had.
          fault    = 1'b1;
          distance = (dot > 0) ? DIST_MIN : DIST_MAX;
        end else begin
          // 2*dot/(qn*sn) rescaled to the fixed point, truncated toward zero.
          mag = (dot < 0) ? -dot : dot;
          quo = (mag << (2 * FRAC_BITS + 1)) / den;
          if (quo > QUOTIENT_CAP) quo = QUOTIENT_CAP;
          distance = (dot < 0) ? NORMED_BASE + quo : NORMED_BASE - quo;
        end
      end
      default: begin
        distance = 0;
      end
    endcase
    if (distance > DIST_MAX) distance = DIST_MAX;
    if (distance < DIST_MIN) distance = DIST_MIN;

    pass = 1'b1;
    if (c.abs_en && ($signed(it.query_power) < $signed(c.abs_floor) ||
                     $signed(it.item_power) < $signed(c.abs_floor))) pass = 1'b0;
    // The power difference can need 33 bits; it is compared without wrapping.
    gap = $signed(it.query_power) - $signed(it.item_power);
    if (gap < 0) gap = -gap;
    if (c.rel_en && gap > $signed({1'b0, c.rel_limit})) pass = 1'b0;
    // The radius plus tolerance is not saturated, so a radius at the top of
    // the range accepts every distance.
    if (c.rad_en && distance > $signed(c.radius) + DISTANCE_TOLERANCE) pass = 1'b0;

    r.distance           = distance[WORD_W-1:0];
    r.accepted           = pass;
    r.divide_fault       = fault;
    r.query_position_out = it.query_position;
    r.item_position_out  = it.item_position;
    r.track_index_out    = it.track_index;
    return r;
  endfunction

  // A value within span of base, landing exactly on the edges a quarter of
  // the time, clamped to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] near(input longint base, input longint span);
    longint v;
    if (span > longint'(DIST_MAX)) span = longint'(DIST_MAX);
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom_range(0, 1) ? base + span : base - span;
    end else begin
      v = base + longint'($urandom_range(0, 32'(2 * span))) - span;
    end
    if (v > longint'(DIST_MAX)) v = longint'(DIST_MAX);
    if (v < longint'(DIST_MIN)) v = longint'(DIST_MIN);
    return v[WORD_W-1:0];
  endfunction

  function automatic item_t make_pair(input logic signed [WORD_W-1:0] dot,
                                      input logic [NORM_W-1:0] qn,
                                      input logic [NORM_W-1:0] sn,
                                      input logic signed [WORD_W-1:0] qp,
                                      input logic signed [WORD_W-1:0] ip);
    item_t it;
    it.dot_sum        = dot;
    it.query_norm     = qn;
    it.item_norm      = sn;
    it.query_power    = qp;
    it.item_power     = ip;
    it.query_position = $urandom;
    it.item_position  = $urandom;
    it.track_index    = $urandom;
    return it;
  endfunction

  // Most random pairs look like real ones: norms of a plausible size and a
  // dot product that a cosine in [-1, 1] allows, with powers around the
  // floor and limit of the phase so the filters land on both sides. The
  // rest have every field drawn over its whole width.
  function automatic item_t random_pair(input cfg_t s);
    item_t  it;
    longint qn;
    longint sn;
    longint dot;
    longint qp;
    longint ip;
    int     k;
    int     jitter;
    if ($urandom_range(0, 9) < 7) begin
      qn     = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1 << 8, 1 << 23);
      sn     = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1 << 8, 1 << 23);
      k      = int'($urandom_range(0, 2048)) - 1024;
      jitter = int'($urandom_range(0, 64)) - 32;
      dot    = (qn * sn) >>> FRAC_BITS;
      dot    = dot * k;
      dot    = dot / 1024 + jitter;
      if (s.mode == MODE_DOT && $urandom_range(0, 7) == 0) begin
        // Straddle the radius edge, where the distance is the dot product.
        dot = near(longint'($signed(s.radius)) + DISTANCE_TOLERANCE, 2);
      end
      qp = near($signed(s.abs_floor), longint'(1) << $urandom_range(0, 20));
      if ($urandom_range(0, 1) == 1) begin
        ip = near(qp, longint'(s.rel_limit) + 1);
      end else begin
        ip = near($signed(s.abs_floor), longint'(1) << $urandom_range(0, 20));
      end
      it = make_pair(dot[WORD_W-1:0], qn[NORM_W-1:0], sn[NORM_W-1:0],
                     qp[WORD_W-1:0], ip[WORD_W-1:0]);
    end else begin
      it = make_pair($urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  // One register write. Bits above the register's width carry junk, which
  // the block must ignore.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    logic [CFG_DATA_W-1:0] data;
    data = (CFG_DATA_W'($urandom) << width) | value;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DISTANCE_MODE:   regs.mode      = data[1:0];
      REG_ABSOLUTE_ENABLE: regs.abs_en    = data[0];
      REG_ABSOLUTE_FLOOR:  regs.abs_floor = data;
      REG_RELATIVE_ENABLE: regs.rel_en    = data[0];
      REG_RELATIVE_LIMIT:  regs.rel_limit = data[NORM_W-1:0];
      REG_RADIUS_ENABLE:   regs.rad_en    = data[0];
      REG_RADIUS:          regs.radius    = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_DISTANCE_MODE, s.mode, 2);
    write_reg(REG_ABSOLUTE_ENABLE, s.abs_en, 1);
    write_reg(REG_ABSOLUTE_FLOOR, s.abs_floor, WORD_W);
    write_reg(REG_RELATIVE_ENABLE, s.rel_en, 1);
    write_reg(REG_RELATIVE_LIMIT, s.rel_limit, NORM_W);
    write_reg(REG_RADIUS_ENABLE, s.rad_en, 1);
    write_reg(REG_RADIUS, s.radius, WORD_W);
  endtask

  // Every request causes exactly one result, so once nothing is pending,
  // offered or owed, the pipeline is empty and registers may be written.
  // The check runs on the falling edge, after the rising edge has settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || item_valid || expected_scores.size() != 0);
  endtask

  // Request side. A request taken at this edge is scored against the
  // registers as they stand; they never change while requests are in flight.
  // A new request is offered only once the previous one is gone, so a
  // stalled payload holds still.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item       <= '0;
    end else begin
      if (item_valid && !item_stall) expected_scores.push_back(score_pair(item, regs));
      if (!item_valid || !item_stall) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          item       <= pending_pairs.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: each result taken is checked field by field against the
  // oldest score owed, and a new stall decision is made every cycle.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_scores.size() == 0) begin
          flag_mismatch("result with no request outstanding", result.distance, '0);
        end else begin
          want = expected_scores.pop_front();
          if (result.distance !== want.distance)
            flag_mismatch("distance", result.distance, want.distance);
          if (result.accepted !== want.accepted)
            flag_mismatch("accepted", result.accepted, want.accepted);
          if (result.divide_fault !== want.divide_fault)
            flag_mismatch("divide_fault", result.divide_fault, want.divide_fault);
          if (result.query_position_out !== want.query_position_out)
            flag_mismatch("query_position_out", result.query_position_out,
                          want.query_position_out);
          if (result.item_position_out !== want.item_position_out)
            flag_mismatch("item_position_out", result.item_position_out,
                          want.item_position_out);
          if (result.track_index_out !== want.track_index_out)
            flag_mismatch("track_index_out", result.track_index_out, want.track_index_out);
        end
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Hang detection: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t  s;
    item_t it;
    int    p;
    int    n;

    regs        = '0;
    regs.mode   = MODE_EUCLID;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: Euclidean, no filters. Extremes of the dot product and
    // norms drive the distance into both rails; unit norms with a unit dot
    // product give exactly zero. The positions go through as all zeros and
    // all ones.
    it = make_pair(0, 0, 0, 0, 0);
    it.query_position = '0;
    it.item_position  = '0;
    it.track_index    = '0;
    pending_pairs.push_back(it);
    it = make_pair(DIST_MAX, 0, 0, 0, 0);
    it.query_position = '1;
    it.item_position  = '1;
    it.track_index    = '1;
    pending_pairs.push_back(it);
    pending_pairs.push_back(make_pair(DIST_MIN, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(DIST_MIN, NORM_MAX, NORM_MAX, 0, 0));
    pending_pairs.push_back(make_pair(DIST_MAX, NORM_MAX, NORM_MAX, 0, 0));
    pending_pairs.push_back(make_pair(ONE, ONE, ONE, 0, 0));
    wait_idle();

    // Normed mode with every filter on but set wide open. Zero norm products
    // with a positive, zero and negative dot product raise the divide fault;
    // the quotient cap is reached with unit-LSB norms. The last pair has the
    // widest possible power difference, which no 31-bit limit allows.
    apply_settings(cfg_t'{mode: MODE_NORMED, abs_en: 1'b1, abs_floor: DIST_MIN,
                          rel_en: 1'b1, rel_limit: NORM_MAX,
                          rad_en: 1'b1, radius: DIST_MAX});
    pending_pairs.push_back(make_pair(ONE, 0, ONE, 0, 0));
    pending_pairs.push_back(make_pair(0, ONE, 0, 0, 0));
    pending_pairs.push_back(make_pair(-ONE, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(ONE, ONE, ONE, 0, 0));
    pending_pairs.push_back(make_pair(-ONE, ONE, ONE, 0, 0));
    pending_pairs.push_back(make_pair(DIST_MAX, 1, 1, 0, 0));
    pending_pairs.push_back(make_pair(DIST_MIN, 1, 1, 0, 0));
    pending_pairs.push_back(make_pair(1, NORM_MAX, NORM_MAX, 0, 0));
    pending_pairs.push_back(make_pair(ONE, ONE, ONE, DIST_MIN, DIST_MAX));
    wait_idle();

    // Dot product mode with tight filters: the radius edge from both sides,
    // a power difference of one against a zero limit, a power just under
    // the floor, and extreme powers that are equal.
    apply_settings(cfg_t'{mode: MODE_DOT, abs_en: 1'b1, abs_floor: 0,
                          rel_en: 1'b1, rel_limit: 0, rad_en: 1'b1, radius: 0});
    pending_pairs.push_back(make_pair(1, ONE, ONE, 0, 0));
    pending_pairs.push_back(make_pair(2, ONE, ONE, 0, 0));
    pending_pairs.push_back(make_pair(0, ONE, ONE, 5, 6));
    pending_pairs.push_back(make_pair(0, ONE, ONE, -1, -1));
    pending_pairs.push_back(make_pair(DIST_MIN, ONE, ONE, DIST_MAX, DIST_MAX));
    wait_idle();

    // The unused mode reports a zero distance, which a negative radius still
    // rejects.
    apply_settings(cfg_t'{mode: MODE_NONE, abs_en: 1'b0, abs_floor: DIST_MAX,
                          rel_en: 1'b0, rel_limit: 0, rad_en: 1'b1, radius: -32'sd2});
    pending_pairs.push_back(make_pair(DIST_MAX, NORM_MAX, 0, 0, 0));
    pending_pairs.push_back(make_pair(ONE, ONE, ONE, DIST_MIN, DIST_MAX));
    wait_idle();

    // Random phases. Each one picks new settings, with two of every six
    // pinned to the extremes of the floor, limit and radius, and cycles
    // through the idling patterns.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      s.mode   = ($urandom_range(0, 9) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
      s.abs_en = $urandom_range(0, 1);
      s.rel_en = $urandom_range(0, 1);
      s.rad_en = $urandom_range(0, 1);
      case (p % 6)
        0: begin
          s.abs_floor = DIST_MIN;
          s.rel_limit = NORM_MAX;
          s.radius    = DIST_MAX;
        end
        1: begin
          s.abs_floor = DIST_MAX;
          s.rel_limit = 0;
          s.radius    = DIST_MIN;
        end
        default: begin
          s.abs_floor = near(0, 1 << 20);
          s.rel_limit = $urandom_range(0, 1 << 20);
          if (s.mode == MODE_NORMED) s.radius = near(NORMED_BASE, NORMED_BASE);
          else s.radius = near(0, 1 << 30);
        end
      endcase
      apply_settings(s);

      case (p % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 49;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 49;
        end
        default: begin
          send_gap_pct = 19;
          stall_pct    = 19;
        end
      endcase

      for (n = 0; n < PAIRS_PER_PHASE; n++) pending_pairs.push_back(random_pair(regs));
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sdf_pkg.sv
src/sdf_front.sv
src/sdf_prep.sv
src/sdf_div_step.sv
src/sdf_back.sv
src/shingle_distance_filter.sv
dv/tb.sv
